FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

FILE: rtl/raeu_pkg.sv
// Package with codes, types and constants of the register ALU execute unit.
package raeu_pkg;
  localparam int NumRegs      = 52;
  localparam int ProgramDepth = 65536;
  localparam logic [5:0] RegCond   = 6'd51;
  localparam logic [5:0] RegIndDst = 6'd29;
  localparam logic [5:0] RegIndSrc = 6'd44;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_RESET = 6'd1, OP_SET = 6'd2, OP_ISET = 6'd3, OP_COPY = 6'd4,
    OP_CONDRST = 6'd5, OP_CONDSET = 6'd6, OP_CONDISET = 6'd7, OP_CONDCPY = 6'd8,
    OP_INDCPY = 6'd9, OP_ADD = 6'd10, OP_SUB = 6'd11, OP_MUL = 6'd12, OP_DIV = 6'd13,
    OP_MOD = 6'd14, OP_INC = 6'd15, OP_DEC = 6'd16, OP_IADD = 6'd17, OP_ISUB = 6'd18,
    OP_IMUL = 6'd19, OP_IDIV = 6'd20, OP_IMOD = 6'd21, OP_IINC = 6'd22, OP_IDEC = 6'd23,
    OP_IABS = 6'd24, OP_AND = 6'd25, OP_OR = 6'd26, OP_XOR = 6'd27, OP_NOT = 6'd28,
    OP_INV = 6'd29, OP_SHL = 6'd30, OP_SHR = 6'd31, OP_ROL = 6'd32, OP_ROR = 6'd33,
    OP_BAND = 6'd34, OP_BOR = 6'd35, OP_BXOR = 6'd36, OP_BNOT = 6'd37, OP_BINV = 6'd38,
    OP_EXIT = 6'd39
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DIV_ZERO = 3'd1, ST_IND_RANGE = 3'd2, ST_NOT_IMPL = 3'd3,
    ST_HALTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE, S_OUT
  } state_t;

  // Divider control between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;
endpackage

FILE: rtl/raeu_if.sv
// Valid/ready channel interfaces for requests and results.
interface raeu_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  req_type;
  logic [5:0]  dest_reg;
  logic [5:0]  left_reg;
  logic [5:0]  right_reg;
  logic [31:0] immediate;
  modport source (output valid, req_type, dest_reg, left_reg, right_reg, immediate,
                  input ready);
  modport sink (input valid, req_type, dest_reg, left_reg, right_reg, immediate,
                output ready);
endinterface

interface raeu_rsp_if #(parameter int PcW = 16);
  logic           valid;
  logic           ready;
  logic [2:0]     status;
  logic           finished;
  logic           wrote;
  logic [5:0]     write_index;
  logic [31:0]    write_value;
  logic [PcW-1:0] next_pc;
  modport source (output valid, status, finished, wrote, write_index, write_value, next_pc,
                  input ready);
  modport sink (input valid, status, finished, wrote, write_index, write_value, next_pc,
                output ready);
endinterface

FILE: rtl/register_alu_execute_unit_core.sv
// Top level of the register ALU execute unit.
// Each request on the req channel is one decoded instruction. It runs against
// a file of 52 32-bit registers and gives exactly one result on the rsp
// channel, carrying status, finish flag, register write and next counter.
// The block takes one request at a time: ready is high only while it waits
// for a new request. A request reads seven registers through the single read
// port of the register file, one address per cycle, then executes in one pass
// of the shared ALU and writes back in the next cycle, except that divide and
// modulo first wait for the bit-serial divider. The result is offered after
// the read, execute and write steps, and no new request is taken until the
// receiver has taken it. A request that arrives while halted skips the read,
// execute and write steps and is answered in the cycle after acceptance.
// Multiplication is a single 32 by 32 product with a registered result.
// The result is held in an output register until the receiver takes it; a
// stalled receiver simply holds the block, and no further request is taken.
// Reset clears the counter, the halted flag and the valid bits of the
// register file at once, so every register reads as zero afterwards.
// Once halted, every request is answered with status halted and no change.
`include "assert_macros.svh"
module register_alu_execute_unit_core #(
  parameter int NumRegs      = raeu_pkg::NumRegs,
  parameter int ProgramDepth = raeu_pkg::ProgramDepth
) (
  input logic clk,
  input logic rst,
  raeu_req_if.sink   req,
  raeu_rsp_if.source rsp
);
  raeu_pkg::state_t state, state_next;
  logic [5:0]  op, d, l, r;
  logic [31:0] imm;
  logic [31:0] a, b, c, dv, id_d, id_s, ind_val;
  logic [2:0]  rstep;
  logic [15:0] pc;
  logic        halted;
  logic        we;
  logic [5:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [63:0] prod;
  raeu_pkg::div_req_t dreq;
  raeu_pkg::div_rsp_t drsp;
  logic [31:0] ma, mb;
  // Result under construction.
  logic [2:0]  st;
  logic        fin, wr;
  logic [5:0]  widx;
  logic [31:0] val;
  logic [2:0]  st_next;
  logic        fin_next, wr_next;
  logic [5:0]  widx_next;
  logic [31:0] val_next;

  raeu_regfile #(.NumRegs(NumRegs)) u_rf (
    .clk, .rst, .we, .waddr, .wdata, .raddr, .rdata
  );
  raeu_divider u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  assign req.ready = (state == raeu_pkg::S_IDLE);

  // Read sequence: left, right, destination, condition, indirect pointers,
  // then the indirect source itself, addressed straight from the word that
  // arrives from the source pointer.
  always_comb begin
    case (rstep)
      3'd0: raddr = l;
      3'd1: raddr = r;
      3'd2: raddr = d;
      3'd3: raddr = raeu_pkg::RegCond;
      3'd4: raddr = raeu_pkg::RegIndDst;
      3'd5: raddr = raeu_pkg::RegIndSrc;
      3'd6: raddr = rdata[5:0];
      default: raddr = l;
    endcase
  end

  assign ma = a[31] ? 32'd0 - a : a;
  assign mb = b[31] ? 32'd0 - b : b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= raeu_pkg::S_IDLE;
      pc     <= 16'd0;
      halted <= 1'b0;
      rstep  <= 3'd0;
    end else begin
      state <= state_next;
      if (state == raeu_pkg::S_IDLE && req.valid) begin
        rstep <= 3'd0;
        if (!halted) pc <= (pc == 16'(ProgramDepth - 1)) ? 16'd0 : pc + 16'd1;
      end
      if (state == raeu_pkg::S_READ) rstep <= rstep + 3'd1;
      if (state == raeu_pkg::S_WRITE && st_next != raeu_pkg::ST_HALTED &&
          (st_next != raeu_pkg::ST_OK || fin_next)) halted <= 1'b1;
    end
  end

  // Register reads land in the cycle after the address.
  always_ff @(posedge clk) begin
    if (state == raeu_pkg::S_IDLE && req.valid) begin
      op <= req.req_type; d <= req.dest_reg; l <= req.left_reg;
      r <= req.right_reg; imm <= req.immediate;
    end
    if (state == raeu_pkg::S_READ || state == raeu_pkg::S_EXEC) begin
      case (rstep)
        3'd1: a <= rdata;
        3'd2: b <= rdata;
        3'd3: dv <= rdata;
        3'd4: c <= rdata;
        3'd5: id_d <= {24'd0, rdata[7:0]};
        3'd6: id_s <= {24'd0, rdata[7:0]};
        3'd7: ind_val <= rdata;
        default: ;
      endcase
    end
    prod <= a * b;
    st <= st_next; fin <= fin_next; wr <= wr_next; widx <= widx_next; val <= val_next;
  end

  always_comb begin
    state_next = state;
    st_next = st; fin_next = fin; wr_next = wr; widx_next = widx; val_next = val;
    we = 1'b0; waddr = widx; wdata = val;
    dreq.start = 1'b0; dreq.dividend = a[31] && (op == raeu_pkg::OP_IDIV ||
      op == raeu_pkg::OP_IMOD) ? ma : a;
    dreq.divisor = (op == raeu_pkg::OP_IDIV || op == raeu_pkg::OP_IMOD) ? mb : b;
    case (state)
      raeu_pkg::S_IDLE: begin
        if (req.valid) state_next = halted ? raeu_pkg::S_OUT : raeu_pkg::S_READ;
        st_next = halted ? raeu_pkg::ST_HALTED : raeu_pkg::ST_OK;
        fin_next = 1'b0; wr_next = 1'b0; widx_next = 6'd0; val_next = 32'd0;
      end
      raeu_pkg::S_READ: if (rstep == 3'd7) state_next = raeu_pkg::S_EXEC;
      raeu_pkg::S_EXEC: begin
        // The indirect source word was captured on the last read step.
        state_next = raeu_pkg::S_WRITE;
        wr_next = 1'b1; widx_next = d;
        case (raeu_pkg::op_t'(op))
          raeu_pkg::OP_NOP:   wr_next = 1'b0;
          raeu_pkg::OP_RESET: val_next = 32'd0;
          raeu_pkg::OP_SET, raeu_pkg::OP_ISET: val_next = imm;
          raeu_pkg::OP_COPY:  val_next = a;
          raeu_pkg::OP_CONDRST: begin wr_next = c != 0; val_next = 32'd0; end
          raeu_pkg::OP_CONDSET, raeu_pkg::OP_CONDISET: begin
            wr_next = c != 0; val_next = imm;
          end
          raeu_pkg::OP_CONDCPY: begin wr_next = c != 0; val_next = a; end
          raeu_pkg::OP_INDCPY: begin
            if (id_d >= 32'(NumRegs) || id_s >= 32'(NumRegs)) begin
              wr_next = 1'b0; st_next = raeu_pkg::ST_IND_RANGE;
            end else begin
              widx_next = id_d[5:0];
              val_next = ind_val;
            end
          end
          raeu_pkg::OP_ADD, raeu_pkg::OP_IADD: val_next = a + b;
          raeu_pkg::OP_SUB, raeu_pkg::OP_ISUB: val_next = a - b;
          raeu_pkg::OP_MUL, raeu_pkg::OP_IMUL: val_next = prod[31:0];
          raeu_pkg::OP_DIV, raeu_pkg::OP_MOD, raeu_pkg::OP_IDIV, raeu_pkg::OP_IMOD: begin
            if (b == 32'd0) begin
              wr_next = 1'b0; st_next = raeu_pkg::ST_DIV_ZERO;
            end else begin
              dreq.start = 1'b1; state_next = raeu_pkg::S_DIV;
            end
          end
          raeu_pkg::OP_INC, raeu_pkg::OP_IINC: val_next = dv + 32'd1;
          raeu_pkg::OP_DEC, raeu_pkg::OP_IDEC: val_next = dv - 32'd1;
          raeu_pkg::OP_IABS: val_next = dv[31] ? 32'd0 - dv : dv;
          raeu_pkg::OP_AND: val_next = {31'd0, (a != 0) && (b != 0)};
          raeu_pkg::OP_OR:  val_next = {31'd0, (a != 0) || (b != 0)};
          raeu_pkg::OP_XOR: val_next = {31'd0, (a != 0) != (b != 0)};
          raeu_pkg::OP_NOT: val_next = {31'd0, a == 0};
          raeu_pkg::OP_INV: val_next = {31'd0, dv == 0};
          raeu_pkg::OP_SHL: val_next = (b >= 32'd32) ? 32'd0 : a << b[4:0];
          raeu_pkg::OP_SHR: val_next = (b >= 32'd32) ? 32'd0 : a >> b[4:0];
          raeu_pkg::OP_ROL: val_next = 32'(({a, a} << b[4:0]) >> 32);
          raeu_pkg::OP_ROR: val_next = 32'({a, a} >> b[4:0]);
          raeu_pkg::OP_BAND: val_next = a & b;
          raeu_pkg::OP_BOR:  val_next = a | b;
          raeu_pkg::OP_BXOR: val_next = a ^ b;
          raeu_pkg::OP_BNOT: val_next = ~a;
          raeu_pkg::OP_BINV: val_next = ~dv;
          raeu_pkg::OP_EXIT: begin wr_next = 1'b0; fin_next = 1'b1; end
          default: begin wr_next = 1'b0; st_next = raeu_pkg::ST_NOT_IMPL; end
        endcase
      end
      raeu_pkg::S_DIV: begin
        if (drsp.done) begin
          state_next = raeu_pkg::S_WRITE;
          case (raeu_pkg::op_t'(op))
            raeu_pkg::OP_DIV:  val_next = drsp.quotient;
            raeu_pkg::OP_MOD:  val_next = drsp.remainder;
            raeu_pkg::OP_IDIV: val_next = (a[31] != b[31]) ? 32'd0 - drsp.quotient
                                                          : drsp.quotient;
            default:           val_next = a[31] ? 32'd0 - drsp.remainder : drsp.remainder;
          endcase
        end
      end
      raeu_pkg::S_WRITE: begin
        // Drop writes to indexes past the file, then commit.
        if (wr && widx >= 6'(NumRegs)) begin
          wr_next = 1'b0;
        end
        if (!(wr && widx < 6'(NumRegs))) begin
          widx_next = 6'd0; val_next = 32'd0;
        end
        we = wr && widx < 6'(NumRegs);
        state_next = raeu_pkg::S_OUT;
      end
      raeu_pkg::S_OUT: if (rsp.ready) state_next = raeu_pkg::S_IDLE;
      default: state_next = raeu_pkg::S_IDLE;
    endcase
  end

  assign rsp.valid       = (state == raeu_pkg::S_OUT);
  assign rsp.status      = st;
  assign rsp.finished    = fin;
  assign rsp.wrote       = wr;
  assign rsp.write_index = widx;
  assign rsp.write_value = val;
  assign rsp.next_pc     = pc;

  `ASSERT_CLK(a_ready_only_idle, clk, rst, req.ready |-> !rsp.valid)
  `ASSERT_CLK(a_wrote_in_range, clk, rst, rsp.valid && rsp.wrote |-> rsp.write_index < 6'(NumRegs))
  `ASSERT_CLK(a_no_write_status, clk, rst, rsp.valid && rsp.status != raeu_pkg::ST_OK |-> !rsp.wrote)
  `ASSERT_CLK(a_halted_sticky, clk, rst, halted |=> halted)
endmodule

FILE: rtl/raeu_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module raeu_divider (
  input  logic               clk,
  input  logic               rst,
  input  raeu_pkg::div_req_t req,
  output raeu_pkg::div_rsp_t rsp
);
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 6'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        quo   <= req.dividend;
        rem   <= 32'd0;
        dvs   <= req.divisor;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem};
endmodule

FILE: rtl/raeu_regfile.sv
// Register file: 52 words held in a memory with one registered read port.
module raeu_regfile #(
  parameter int NumRegs = raeu_pkg::NumRegs
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [5:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [5:0]  raddr,
  output logic [31:0] rdata
);
  logic [31:0]        mem [NumRegs];
  logic [NumRegs-1:0] vld;
  logic [31:0]        mem_q;
  logic               hit;

  always_ff @(posedge clk) begin
    if (we && waddr < 6'(NumRegs)) mem[waddr] <= wdata;
    if (raddr < 6'(NumRegs)) mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      hit <= 1'b0;
    end else begin
      if (we && waddr < 6'(NumRegs)) vld[waddr] <= 1'b1;
      hit <= (raddr < 6'(NumRegs)) && vld[raddr];
    end
  end

  assign rdata = hit ? mem_q : 32'd0;
endmodule

FILE: verif/raeu_tb_if.sv
// Package with the expected-result record used by the testbench.
`timescale 1ns / 100ps
package raeu_tb_pkg;
  // One expected result, in the order the unit must produce them.
  typedef struct packed {
    logic [2:0]  status;
    logic        finished;
    logic        wrote;
    logic [5:0]  write_index;
    logic [31:0] write_value;
    logic [15:0] next_pc;
  } outcome_t;
endpackage

FILE: verif/testbench.sv
// Self-checking testbench for the register ALU execute unit.
`timescale 1ns / 100ps
module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;

  raeu_req_if req ();
  raeu_rsp_if #(.PcW(16)) rsp ();

  register_alu_execute_unit_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the architectural state.
  logic [31:0] shadow_regs [0:51];
  logic [15:0] shadow_pc;
  logic        shadow_halted;

  raeu_tb_pkg::outcome_t expected_outcomes [$];
  int       error_count = 0;
  int       idle_cycles = 0;
  bit       calm_mode;   // when set, neither side inserts gaps

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] read_reg(input logic [5:0] idx);
    return (idx < 52) ? shadow_regs[idx] : 32'd0;
  endfunction

  function automatic logic [31:0] negate(input logic [31:0] v);
    return 32'd0 - v;
  endfunction

  function automatic logic [31:0] rotate_left(input logic [31:0] n, input logic [4:0] k);
    return (k == 0) ? n : ((n << k) | (n >> (6'd32 - k)));
  endfunction

  // Executes one instruction on the shadow state and returns its outcome.
  function automatic raeu_tb_pkg::outcome_t execute_instr(input logic [5:0] op,
                                                          input logic [5:0] d,
                                                          input logic [5:0] l,
                                                          input logic [5:0] r,
                                                          input logic [31:0] imm);
    raeu_tb_pkg::outcome_t o;
    logic [31:0] a, b, v, ma, mb, di_w, si_w;
    logic [5:0]  widx;
    logic        wr, cond;
    logic [7:0]  di, si;
    o = '0;
    a = read_reg(l);
    b = read_reg(r);
    cond = read_reg(raeu_pkg::RegCond) != 0;
    wr = 1'b0;
    widx = d;
    v = 32'd0;
    if (shadow_halted) begin
      o.status = raeu_pkg::ST_HALTED;
      o.next_pc = shadow_pc;
      return o;
    end
    shadow_pc = shadow_pc + 16'd1;
    ma = a[31] ? negate(a) : a;
    mb = b[31] ? negate(b) : b;
    case (op)
      raeu_pkg::OP_NOP: ;
      raeu_pkg::OP_RESET: wr = 1'b1;
      raeu_pkg::OP_SET, raeu_pkg::OP_ISET: begin wr = 1'b1; v = imm; end
      raeu_pkg::OP_COPY: begin wr = 1'b1; v = a; end
      raeu_pkg::OP_CONDRST: wr = cond;
      raeu_pkg::OP_CONDSET, raeu_pkg::OP_CONDISET: begin wr = cond; v = imm; end
      raeu_pkg::OP_CONDCPY: begin wr = cond; v = a; end
      raeu_pkg::OP_INDCPY: begin
        di_w = read_reg(raeu_pkg::RegIndDst);
        si_w = read_reg(raeu_pkg::RegIndSrc);
        di = di_w[7:0];
        si = si_w[7:0];
        if (di >= 52 || si >= 52) o.status = raeu_pkg::ST_IND_RANGE;
        else begin wr = 1'b1; widx = di[5:0]; v = shadow_regs[si]; end
      end
      raeu_pkg::OP_ADD, raeu_pkg::OP_IADD: begin wr = 1'b1; v = a + b; end
      raeu_pkg::OP_SUB, raeu_pkg::OP_ISUB: begin wr = 1'b1; v = a - b; end
      raeu_pkg::OP_MUL, raeu_pkg::OP_IMUL: begin wr = 1'b1; v = a * b; end
      raeu_pkg::OP_DIV: if (b == 0) o.status = raeu_pkg::ST_DIV_ZERO;
        else begin wr = 1'b1; v = a / b; end
      raeu_pkg::OP_MOD: if (b == 0) o.status = raeu_pkg::ST_DIV_ZERO;
        else begin wr = 1'b1; v = a % b; end
      raeu_pkg::OP_INC, raeu_pkg::OP_IINC: begin wr = 1'b1; v = read_reg(d) + 32'd1; end
      raeu_pkg::OP_DEC, raeu_pkg::OP_IDEC: begin wr = 1'b1; v = read_reg(d) - 32'd1; end
      raeu_pkg::OP_IDIV: if (b == 0) o.status = raeu_pkg::ST_DIV_ZERO;
        else begin wr = 1'b1; v = (a[31] != b[31]) ? negate(ma / mb) : ma / mb; end
      raeu_pkg::OP_IMOD: if (b == 0) o.status = raeu_pkg::ST_DIV_ZERO;
        else begin wr = 1'b1; v = a[31] ? negate(ma % mb) : ma % mb; end
      raeu_pkg::OP_IABS: begin wr = 1'b1; v = read_reg(d); v = v[31] ? negate(v) : v; end
      raeu_pkg::OP_AND: begin wr = 1'b1; v = {31'd0, (a != 0 && b != 0)}; end
      raeu_pkg::OP_OR: begin wr = 1'b1; v = {31'd0, (a != 0 || b != 0)}; end
      raeu_pkg::OP_XOR: begin wr = 1'b1; v = {31'd0, ((a != 0) != (b != 0))}; end
      raeu_pkg::OP_NOT: begin wr = 1'b1; v = {31'd0, (a == 0)}; end
      raeu_pkg::OP_INV: begin wr = 1'b1; v = {31'd0, (read_reg(d) == 0)}; end
      raeu_pkg::OP_SHL: begin wr = 1'b1; v = (b >= 32) ? 32'd0 : a << b[4:0]; end
      raeu_pkg::OP_SHR: begin wr = 1'b1; v = (b >= 32) ? 32'd0 : a >> b[4:0]; end
      raeu_pkg::OP_ROL: begin wr = 1'b1; v = rotate_left(a, b[4:0]); end
      raeu_pkg::OP_ROR: begin wr = 1'b1; v = rotate_left(a, 5'd0 - b[4:0]); end
      raeu_pkg::OP_BAND: begin wr = 1'b1; v = a & b; end
      raeu_pkg::OP_BOR: begin wr = 1'b1; v = a | b; end
      raeu_pkg::OP_BXOR: begin wr = 1'b1; v = a ^ b; end
      raeu_pkg::OP_BNOT: begin wr = 1'b1; v = ~a; end
      raeu_pkg::OP_BINV: begin wr = 1'b1; v = ~read_reg(d); end
      raeu_pkg::OP_EXIT: begin o.finished = 1'b1; shadow_halted = 1'b1; end
      default: o.status = raeu_pkg::ST_NOT_IMPL;
    endcase
    if (o.status != raeu_pkg::ST_OK) shadow_halted = 1'b1;
    if (wr && widx >= 52) wr = 1'b0;
    if (wr) begin
      shadow_regs[widx] = v;
      o.wrote = 1'b1;
      o.write_index = widx;
      o.write_value = v;
    end
    o.next_pc = shadow_pc;
    return o;
  endfunction

  // True when the instruction would halt the unit on the current shadow state.
  function automatic logic would_halt(input logic [5:0] op, input logic [5:0] r);
    logic [31:0] di_w, si_w;
    di_w = read_reg(raeu_pkg::RegIndDst);
    si_w = read_reg(raeu_pkg::RegIndSrc);
    case (op)
      raeu_pkg::OP_DIV, raeu_pkg::OP_MOD, raeu_pkg::OP_IDIV, raeu_pkg::OP_IMOD:
        return read_reg(r) == 32'd0;
      raeu_pkg::OP_INDCPY: return (di_w[7:0] >= 8'd52) || (si_w[7:0] >= 8'd52);
      default: return 1'b0;
    endcase
  endfunction

  // Shadow reset, matching what the block's reset does.
  task automatic clear_shadow();
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_pc = '0;
    shadow_halted = 1'b0;
  endtask

  // Sends one request, with an optional random gap before it. Valid stays high
  // after acceptance until the next request or a gap replaces it.
  task automatic send_instr(input logic [5:0] op, input logic [5:0] d, input logic [5:0] l,
                            input logic [5:0] r, input logic [31:0] imm);
    if (!calm_mode && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= op;
    req.dest_reg  <= d;
    req.left_reg  <= l;
    req.right_reg <= r;
    req.immediate <= imm;
    do @(posedge clk); while (!req.ready);
    // Predict at acceptance so the shadow state follows request order.
    expected_outcomes.push_back(execute_instr(op, d, l, r, imm));
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Register index mostly in range, occasionally one of the unused slots.
  function automatic logic [5:0] pick_reg();
    return ($urandom_range(0, 15) == 0) ? 6'($urandom_range(52, 63))
                                        : 6'($urandom_range(0, 51));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // Resets the block and its shadow. Only called once, at the start.
  task automatic apply_reset();
    clear_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Extremes of the operands and every operation but exit once in a loop, with the special cases.
  task automatic test_directed();
    int k;
    send_instr(raeu_pkg::OP_SET, 6'd1, 6'd0, 6'd0, 32'h8000_0000);
    send_instr(raeu_pkg::OP_SET, 6'd2, 6'd0, 6'd0, 32'hffff_ffff);
    send_instr(raeu_pkg::OP_IDIV, 6'd3, 6'd1, 6'd2, 32'd0);   // minimum over minus one
    send_instr(raeu_pkg::OP_IMOD, 6'd4, 6'd1, 6'd2, 32'd0);
    send_instr(raeu_pkg::OP_IABS, 6'd1, 6'd0, 6'd0, 32'd0);   // absolute of the minimum
    send_instr(raeu_pkg::OP_SET, 6'd5, 6'd0, 6'd0, 32'd32);
    send_instr(raeu_pkg::OP_SHL, 6'd6, 6'd2, 6'd5, 32'd0);    // shift by 32 gives zero
    send_instr(raeu_pkg::OP_ROL, 6'd7, 6'd1, 6'd5, 32'd0);    // rotate amount wraps
    send_instr(raeu_pkg::OP_SET, raeu_pkg::RegCond, 6'd0, 6'd0, 32'd0);
    send_instr(raeu_pkg::OP_CONDSET, 6'd8, 6'd0, 6'd0, 32'h1234); // condition clear
    send_instr(raeu_pkg::OP_SET, raeu_pkg::RegCond, 6'd0, 6'd0, 32'd1);
    send_instr(raeu_pkg::OP_CONDSET, 6'd8, 6'd0, 6'd0, 32'h1234);
    send_instr(raeu_pkg::OP_SET, 6'd63, 6'd0, 6'd0, 32'hdead);  // write to an unused index
    send_instr(raeu_pkg::OP_COPY, 6'd9, 6'd60, 6'd0, 32'd0);
    send_instr(raeu_pkg::OP_SET, raeu_pkg::RegIndDst, 6'd0, 6'd0, 32'h0000_0110);
    send_instr(raeu_pkg::OP_SET, raeu_pkg::RegIndSrc, 6'd0, 6'd0, 32'd2);
    send_instr(raeu_pkg::OP_INDCPY, 6'd0, 6'd0, 6'd0, 32'd0);
    for (k = 0; k < 40; k++)
      send_instr((k == int'(raeu_pkg::OP_EXIT)) ? raeu_pkg::OP_NOP : raeu_pkg::op_t'(k),
                 pick_reg(), pick_reg(), pick_reg(), pick_value());
    send_instr(6'd63, 6'h3f, 6'h3f, 6'h3f, 32'hffff_ffff); // unsupported code halts
    send_instr(raeu_pkg::OP_SET, 6'd10, 6'd0, 6'd0, 32'd5);  // ignored while halted
  endtask

  // Random instruction streams. The block cannot be reset again, so anything
  // that would halt it is turned into a no-op and the unit stays live.
  task automatic test_random(input int count);
    int          n;
    logic [5:0]  op, d, l, r;
    for (n = 0; n < count; n++) begin
      op = 6'($urandom_range(0, 38));
      d = pick_reg();
      l = pick_reg();
      r = pick_reg();
      if (op == raeu_pkg::OP_EXIT || would_halt(op, r)) op = raeu_pkg::OP_NOP;
      send_instr(op, d, l, r, pick_value());
      if (n == count / 2) wait_drained();
    end
  endtask

  // Exit and random requests sent while halted: checks the stuck state.
  task automatic test_halted_tail();
    int n;
    send_instr(raeu_pkg::OP_EXIT, 6'd0, 6'd0, 6'd0, 32'd0);
    for (n = 0; n < 30; n++)
      send_instr(6'($urandom_range(0, 63)), 6'($urandom), 6'($urandom), 6'($urandom),
                 $urandom);
  endtask

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    raeu_tb_pkg::outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", rsp.write_value, 32'd0);
      end else begin
        want = expected_outcomes.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.finished !== want.finished)
          report_mismatch("finished", 32'(rsp.finished), 32'(want.finished));
        if (rsp.wrote !== want.wrote)
          report_mismatch("wrote", 32'(rsp.wrote), 32'(want.wrote));
        if (rsp.write_index !== want.write_index)
          report_mismatch("write_index", 32'(rsp.write_index), 32'(want.write_index));
        if (rsp.write_value !== want.write_value)
          report_mismatch("write_value", rsp.write_value, want.write_value);
        if (rsp.next_pc !== want.next_pc)
          report_mismatch("next_pc", 32'(rsp.next_pc), 32'(want.next_pc));
      end
    end
  end

  // Receiver back-pressure in bursts, switched off in calm mode.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (calm_mode) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    calm_mode = 1'b0;
    req.valid = 1'b0;
    req.req_type = '0;
    req.dest_reg = '0;
    req.left_reg = '0;
    req.right_reg = '0;
    req.immediate = '0;
    apply_reset();
    // Directed part ends in a halt, so it runs last; random runs first.
    test_random(1100);
    wait_drained();     // sender holds off until every result is back
    calm_mode = 1'b1;
    test_random(300);
    test_directed();
    test_halted_tail();
    wait_drained();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
